>>> rtl/crsc_pkg.sv
// ----------------------------------------------------------------------------
// crsc_pkg
// Shared types, constants and helper functions of the chunked record stream
// checker: parse phases, chunk kinds, error codes, result bundle and CRC step.
// ----------------------------------------------------------------------------
package crsc_pkg;

   localparam int HEADER_BYTES = 64;
   localparam int OFF_W        = $clog2(HEADER_BYTES);

   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
   localparam logic [15:0] GT2R_UNIT_CNT = 16'h0301;

   localparam logic [31:0] TYPE_META = 32'h4154454D;
   localparam logic [31:0] TYPE_CONF = 32'h464E4F43;
   localparam logic [31:0] TYPE_RUNO = 32'h4F4E5552;
   localparam logic [31:0] TYPE_GT2R = 32'h52325447;

   localparam logic [OFF_W-1:0] OFF_MAGIC_END  = OFF_W'(8);
   localparam logic [OFF_W-1:0] OFF_FIXED_END  = OFF_W'(16);
   localparam logic [OFF_W-1:0] OFF_PART       = OFF_W'(60);
   localparam logic [OFF_W-1:0] OFF_HDR_LAST   = OFF_W'(HEADER_BYTES - 1);
   localparam logic [OFF_W-1:0] OFF_TYPE_END   = OFF_W'(4);
   localparam logic [OFF_W-1:0] OFF_TYPE_LAST  = OFF_W'(3);
   localparam logic [OFF_W-1:0] OFF_CHDR_LAST  = OFF_W'(15);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_CHUNKHDR = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DRAIN   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_META    = 3'd0,
      KIND_CONF    = 3'd1,
      KIND_RUNO    = 3'd2,
      KIND_GT2R    = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_MAGIC  = 3'd1,
      ERR_HEADER = 3'd2,
      ERR_TRUNC  = 3'd3,
      ERR_CRC    = 3'd4,
      ERR_UNIT   = 3'd5
   } err_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_data;
      kind_type    chunk_kind;
      logic        chunk_start;
      logic        chunk_done;
      logic        header_ok;
      err_type     error_code;
      logic        stream_done;
      logic [7:0]  part_code;
      logic [15:0] chunk_rev;
      logic [15:0] chunk_flags;
      logic [31:0] payload_length;
   } result_type;

   // fixed bytes at the start of the file header
   function automatic logic [7:0] hdr_expect(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h48;
         4'd1:    val = 8'h4D;
         4'd2:    val = 8'h49;
         4'd3:    val = 8'h52;
         4'd4:    val = 8'h41;
         4'd5:    val = 8'h57;
         4'd6:    val = 8'h30;
         4'd7:    val = 8'h32;
         4'd8:    val = 8'h40;
         4'd10:   val = 8'h02;
         4'd12:   val = 8'h01;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic kind_type kind_of(input logic [31:0] word);
      kind_type k;
      if (word == TYPE_META) begin
         k = KIND_META;
      end else if (word == TYPE_CONF) begin
         k = KIND_CONF;
      end else if (word == TYPE_RUNO) begin
         k = KIND_RUNO;
      end else if (word == TYPE_GT2R) begin
         k = KIND_GT2R;
      end else begin
         k = KIND_UNKNOWN;
      end
      return k;
   endfunction

   // reflected crc-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'h0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

>>> rtl/crsc_parser.sv
// ----------------------------------------------------------------------------
// crsc_parser
// Parse state and single-pass update: header check, chunk header fields,
// payload crc and gt2r checks, error latch and end-of-file handling.
// ----------------------------------------------------------------------------
module crsc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data,
   input  logic                 eof,
   output crsc_pkg::result_type result
);
   import crsc_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [OFF_W-1:0] off_ff, off_in;
   err_type          err_ff, err_in;
   logic [31:0]      left_ff, left_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      exp_ff, exp_in;
   logic [23:0]      type_ff, type_in;
   kind_type         kind_ff, kind_in;
   logic [31:0]      vf_ff, vf_in;
   logic [15:0]      uc_ff, uc_in;
   logic [7:0]       part_ff, part_in;

   logic             do_finish;
   logic [31:0]      fin_crc;
   logic [31:0]      fin_exp;
   logic [15:0]      fin_uc;
   logic [31:0]      crc_step;
   logic [31:0]      left_dec;

   assign crc_step = crc_byte(crc_ff, data);
   assign left_dec = left_ff - 32'd1;

   always_comb begin
      phase_in  = phase_ff;
      off_in    = off_ff;
      err_in    = err_ff;
      left_in   = left_ff;
      crc_in    = crc_ff;
      exp_in    = exp_ff;
      type_in   = type_ff;
      kind_in   = kind_ff;
      vf_in     = vf_ff;
      uc_in     = uc_ff;
      part_in   = part_ff;
      do_finish = 1'b0;
      fin_crc   = crc_ff;
      fin_exp   = exp_ff;
      fin_uc    = uc_ff;
      result    = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (off_ff < OFF_FIXED_END && data != hdr_expect(off_ff[3:0])) begin
               err_in   = (off_ff < OFF_MAGIC_END) ? ERR_MAGIC : ERR_HEADER;
               phase_in = PH_DRAIN;
            end else begin
               if (off_ff == OFF_PART) begin
                  part_in = data;
               end
               if (off_ff == OFF_HDR_LAST) begin
                  result.header_ok = 1'b1;
                  result.part_code = (off_ff == OFF_PART) ? data : part_ff;
                  phase_in         = PH_CHUNKHDR;
                  off_in           = '0;
               end else begin
                  off_in = off_ff + OFF_W'(1);
               end
            end
         end
         PH_CHUNKHDR: begin
            case (off_ff[3:2])
               2'd0: begin
                  case (off_ff[1:0])
                     2'd0:    type_in[7:0]   = data;
                     2'd1:    type_in[15:8]  = data;
                     2'd2:    type_in[23:16] = data;
                     default: kind_in = kind_of({data, type_ff});
                  endcase
               end
               2'd1: begin
                  case (off_ff[1:0])
                     2'd0:    vf_in[7:0]   = data;
                     2'd1:    vf_in[15:8]  = data;
                     2'd2:    vf_in[23:16] = data;
                     default: vf_in[31:24] = data;
                  endcase
               end
               2'd2: begin
                  case (off_ff[1:0])
                     2'd0:    left_in[7:0]   = data;
                     2'd1:    left_in[15:8]  = data;
                     2'd2:    left_in[23:16] = data;
                     default: left_in[31:24] = data;
                  endcase
               end
               default: begin
                  case (off_ff[1:0])
                     2'd0:    exp_in[7:0]   = data;
                     2'd1:    exp_in[15:8]  = data;
                     2'd2:    exp_in[23:16] = data;
                     default: exp_in[31:24] = data;
                  endcase
               end
            endcase
            if (off_ff == OFF_CHDR_LAST) begin
               result.chunk_kind     = kind_ff;
               result.chunk_start    = 1'b1;
               result.chunk_rev      = vf_ff[15:0];
               result.chunk_flags    = vf_ff[31:16];
               result.payload_length = left_ff;
               crc_in = CRC_INIT;
               uc_in  = '0;
               off_in = '0;
               if (left_ff == 32'd0) begin
                  do_finish = 1'b1;
                  fin_crc   = CRC_INIT;
                  fin_uc    = '0;
                  fin_exp   = {data, exp_ff[23:0]};
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               off_in = off_ff + OFF_W'(1);
            end
         end
         PH_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_data  = data;
            result.chunk_kind    = kind_ff;
            crc_in  = crc_step;
            left_in = left_dec;
            if (off_ff == OFF_W'(0)) begin
               uc_in[7:0] = data;
               off_in     = OFF_W'(1);
            end else if (off_ff == OFF_W'(1)) begin
               uc_in[15:8] = data;
               off_in      = OFF_W'(2);
            end
            if (left_dec == 32'd0) begin
               do_finish = 1'b1;
               fin_crc   = crc_step;
               fin_uc    = uc_in;
               fin_exp   = exp_ff;
            end
         end
         default: begin
         end
      endcase

      if (do_finish) begin
         phase_in = PH_CHUNKHDR;
         off_in   = '0;
         if (~fin_crc != fin_exp) begin
            err_in   = ERR_CRC;
            phase_in = PH_DRAIN;
         end else if (kind_ff == KIND_GT2R && fin_uc != GT2R_UNIT_CNT) begin
            err_in   = ERR_UNIT;
            phase_in = PH_DRAIN;
         end else begin
            result.chunk_done = 1'b1;
         end
      end

      if (eof) begin
         if (err_in == ERR_NONE && !(phase_in == PH_CHUNKHDR && off_in < OFF_TYPE_END)) begin
            err_in = ERR_TRUNC;
         end
         result.stream_done = 1'b1;
      end
      result.error_code = err_in;

      // back to the header phase for the next file
      if (eof) begin
         phase_in = PH_HEADER;
         off_in   = '0;
         err_in   = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         off_ff   <= '0;
         err_ff   <= ERR_NONE;
      end else if (step) begin
         phase_ff <= phase_in;
         off_ff   <= off_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         left_ff <= left_in;
         crc_ff  <= crc_in;
         exp_ff  <= exp_in;
         type_ff <= type_in;
         kind_ff <= kind_in;
         vf_ff   <= vf_in;
         uc_ff   <= uc_in;
         part_ff <= part_in;
      end
   end

endmodule

>>> rtl/crsc_out_stage.sv
// ----------------------------------------------------------------------------
// crsc_out_stage
// Result register with valid and stall toward the consumer.
// ----------------------------------------------------------------------------
module crsc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  crsc_pkg::result_type in_result,
   output logic                 out_valid,
   input  logic                 out_stall,
   output crsc_pkg::result_type out_result
);
   import crsc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;
   logic       load;

   assign in_stall = valid_ff && out_stall;
   assign load     = in_valid && !in_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

>>> rtl/chunked_record_stream_checker.sv
// ----------------------------------------------------------------------------
// chunked_record_stream_checker
// Byte-stream checker for a chunked record file: header check, chunk header
// parsing, payload pass-through with crc-32 and gt2r checks, latched error.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  stream byte, end of file
//   rsp      out        rsp_valid/rsp_stall  one result per byte
//
// one byte per clock while rsp_stall is low; input register, then result
// register, the crc byte step and field capture sit between them
// synchronous active-high reset returns the parser to the header phase
// a stalled result register holds the byte in the input register; req_stall
// rises only while both registers are full and the result is stalled
// ----------------------------------------------------------------------------
module chunked_record_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_payload_valid,
   output logic [7:0]  rsp_payload_data,
   output logic [2:0]  rsp_chunk_kind,
   output logic        rsp_chunk_start,
   output logic        rsp_chunk_done,
   output logic        rsp_header_ok,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_stream_done,
   output logic [7:0]  rsp_part_code,
   output logic [15:0] rsp_chunk_rev,
   output logic [15:0] rsp_chunk_flags,
   output logic [31:0] rsp_payload_length
);
   import crsc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       eof_ff;
   logic       accept;
   logic       advance;
   logic       out_stall;
   result_type step_result;
   result_type rsp_result;

   assign req_stall = in_valid_ff && out_stall;
   assign accept    = req_valid && !req_stall;
   assign advance   = in_valid_ff && !out_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_stream_byte;
         eof_ff  <= req_end_of_file;
      end
   end

   crsc_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .data   (byte_ff),
      .eof    (eof_ff),
      .result (step_result)
   );

   crsc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_stall   (out_stall),
      .in_result  (step_result),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (rsp_result)
   );

   assign rsp_payload_valid  = rsp_result.payload_valid;
   assign rsp_payload_data   = rsp_result.payload_data;
   assign rsp_chunk_kind     = rsp_result.chunk_kind;
   assign rsp_chunk_start    = rsp_result.chunk_start;
   assign rsp_chunk_done     = rsp_result.chunk_done;
   assign rsp_header_ok      = rsp_result.header_ok;
   assign rsp_error_code     = rsp_result.error_code;
   assign rsp_stream_done    = rsp_result.stream_done;
   assign rsp_part_code      = rsp_result.part_code;
   assign rsp_chunk_rev      = rsp_result.chunk_rev;
   assign rsp_chunk_flags    = rsp_result.chunk_flags;
   assign rsp_payload_length = rsp_result.payload_length;

endmodule

>>> tb/chunk_parse_monitor.sv
// ----------------------------------------------------------------------------
// chunk_parse_monitor
// Watches both channels of the chunked record stream checker. Every accepted
// input transaction runs through a byte-level model of the header and chunk
// parser; the expected result is queued and matched field by field against
// the next accepted result transaction. Mismatch and file/chunk counts are
// handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crsc_tb_pkg;

   localparam int PART_OFFSET   = 60;
   localparam int MAGIC_BYTES   = 8;
   localparam int FIXED_BYTES   = 16;
   localparam int CHUNK_HDR_LEN = 16;

   localparam logic [7:0] FILE_PREAMBLE [FIXED_BYTES] = '{
      8'h48, 8'h4D, 8'h49, 8'h52, 8'h41, 8'h57, 8'h30, 8'h32,
      8'h40, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00
   };

   // reflected crc-32, data bits folded in one at a time
   function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc,
                                                 input logic [7:0] data);
      logic [31:0] c;
      c = acc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ data[i]) begin
            c = {1'b0, c[31:1]} ^ crsc_pkg::CRC_POLY;
         end else begin
            c = {1'b0, c[31:1]};
         end
      end
      return c;
   endfunction

endpackage

module chunk_parse_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_end_of_file,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_payload_valid,
   input  logic [7:0]  rsp_payload_data,
   input  logic [2:0]  rsp_chunk_kind,
   input  logic        rsp_chunk_start,
   input  logic        rsp_chunk_done,
   input  logic        rsp_header_ok,
   input  logic [2:0]  rsp_error_code,
   input  logic        rsp_stream_done,
   input  logic [7:0]  rsp_part_code,
   input  logic [15:0] rsp_chunk_rev,
   input  logic [15:0] rsp_chunk_flags,
   input  logic [31:0] rsp_payload_length,
   output int          mismatch_count,
   output int          awaiting,
   output int          file_count,
   output int          bad_file_count,
   output int          chunk_count
);

   import crsc_pkg::*;
   import crsc_tb_pkg::*;

   phase_type   phase;
   logic [7:0]  offset;
   logic [31:0] remaining;
   logic [31:0] crc_acc;
   logic [31:0] crc_field;
   logic [31:0] tag;
   kind_type    kind;
   logic [31:0] ver_flags;
   logic [7:0]  unit_byte;
   logic [7:0]  count_byte;
   err_type     err;
   logic [7:0]  part;

   result_type  expected_results[$];

   task automatic clear_parser();
      phase      = PH_HEADER;
      offset     = '0;
      remaining  = '0;
      crc_acc    = CRC_INIT;
      crc_field  = '0;
      tag        = '0;
      kind       = KIND_META;
      ver_flags  = '0;
      unit_byte  = '0;
      count_byte = '0;
      err        = ERR_NONE;
      part       = '0;
   endtask

   function automatic kind_type classify_tag(input logic [31:0] word);
      case (word)
         TYPE_META: return KIND_META;
         TYPE_CONF: return KIND_CONF;
         TYPE_RUNO: return KIND_RUNO;
         TYPE_GT2R: return KIND_GT2R;
         default:   return KIND_UNKNOWN;
      endcase
   endfunction

   // end of payload: crc first, then the gt2r unit and count
   function automatic logic close_chunk();
      phase  = PH_CHUNKHDR;
      offset = '0;
      if (~crc_acc != crc_field) begin
         err   = ERR_CRC;
         phase = PH_DRAIN;
         return 1'b0;
      end
      if (kind == KIND_GT2R && (unit_byte != 8'd1 || count_byte != 8'd3)) begin
         err   = ERR_UNIT;
         phase = PH_DRAIN;
         return 1'b0;
      end
      chunk_count++;
      return 1'b1;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic eof, output result_type r);
      r = '0;
      case (phase)
         PH_HEADER: begin
            if (offset < FIXED_BYTES && b != FILE_PREAMBLE[offset[3:0]]) begin
               err   = (offset < MAGIC_BYTES) ? ERR_MAGIC : ERR_HEADER;
               phase = PH_DRAIN;
            end else begin
               if (offset == PART_OFFSET) begin
                  part = b;
               end
               if (offset == HEADER_BYTES - 1) begin
                  r.header_ok = 1'b1;
                  r.part_code = part;
                  phase       = PH_CHUNKHDR;
                  offset      = '0;
               end else begin
                  offset = offset + 8'd1;
               end
            end
         end
         PH_CHUNKHDR: begin
            if (offset < 4) begin
               tag[8*offset[1:0] +: 8] = b;
               if (offset == 3) begin
                  kind = classify_tag(tag);
               end
            end else if (offset < 8) begin
               ver_flags[8*offset[1:0] +: 8] = b;
            end else if (offset < 12) begin
               remaining[8*offset[1:0] +: 8] = b;
            end else begin
               crc_field[8*offset[1:0] +: 8] = b;
            end
            if (offset == CHUNK_HDR_LEN - 1) begin
               r.chunk_kind     = kind;
               r.chunk_start    = 1'b1;
               r.chunk_rev      = ver_flags[15:0];
               r.chunk_flags    = ver_flags[31:16];
               r.payload_length = remaining;
               crc_acc    = CRC_INIT;
               unit_byte  = '0;
               count_byte = '0;
               offset     = '0;
               if (remaining == 0) begin
                  r.chunk_done = close_chunk();
               end else begin
                  phase = PH_PAYLOAD;
               end
            end else begin
               offset = offset + 8'd1;
            end
         end
         PH_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_data  = b;
            r.chunk_kind    = kind;
            crc_acc = crc_fold_byte(crc_acc, b);
            if (offset == 0) begin
               unit_byte = b;
               offset    = 8'd1;
            end else if (offset == 1) begin
               count_byte = b;
               offset     = 8'd2;
            end
            remaining = remaining - 32'd1;
            if (remaining == 0) begin
               r.chunk_done = close_chunk();
            end
         end
         default: begin
         end
      endcase
      if (eof) begin
         // only a chunk boundary or a partial type field may end the file
         if (err == ERR_NONE && !(phase == PH_CHUNKHDR && offset < 4)) begin
            err = ERR_TRUNC;
         end
         r.stream_done = 1'b1;
         file_count++;
         if (err != ERR_NONE) begin
            bad_file_count++;
         end
      end
      r.error_code = err;
      if (eof) begin
         clear_parser();
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   initial begin
      mismatch_count = 0;
      awaiting       = 0;
      file_count     = 0;
      bad_file_count = 0;
      chunk_count    = 0;
      clear_parser();
   end

   always @(posedge clock) begin : sample
      result_type want;
      result_type next_result;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_stream_byte, req_end_of_file, next_result);
            expected_results.insert(expected_results.size(), next_result);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with nothing outstanding");
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("payload_valid", want.payload_valid, rsp_payload_valid);
               check_field("payload_data", want.payload_data, rsp_payload_data);
               check_field("chunk_kind", want.chunk_kind, rsp_chunk_kind);
               check_field("chunk_start", want.chunk_start, rsp_chunk_start);
               check_field("chunk_done", want.chunk_done, rsp_chunk_done);
               check_field("header_ok", want.header_ok, rsp_header_ok);
               check_field("error_code", want.error_code, rsp_error_code);
               check_field("stream_done", want.stream_done, rsp_stream_done);
               check_field("part_code", want.part_code, rsp_part_code);
               check_field("chunk_rev", want.chunk_rev, rsp_chunk_rev);
               check_field("chunk_flags", want.chunk_flags, rsp_chunk_flags);
               check_field("payload_length", want.payload_length, rsp_payload_length);
            end
         end
      end
      awaiting = expected_results.size();
   end

endmodule

>>> tb/chunked_record_stream_checker_tb.sv
// ----------------------------------------------------------------------------
// chunked_record_stream_checker_tb
// Feeds whole files, one byte per transaction, into the stream checker:
// a short list of hand-built files for header faults, empty and short chunks,
// crc and gt2r faults and early ends, then random files; any file may get
// random idle gaps and result stalls. The monitor does all the checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunked_record_stream_checker_tb;

   import crsc_pkg::*;
   import crsc_tb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {
      FAULT_NONE,
      FAULT_CRC,
      FAULT_UNIT
   } chunk_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_data;
   logic [2:0]  rsp_chunk_kind;
   logic        rsp_chunk_start;
   logic        rsp_chunk_done;
   logic        rsp_header_ok;
   logic [2:0]  rsp_error_code;
   logic        rsp_stream_done;
   logic [7:0]  rsp_part_code;
   logic [15:0] rsp_chunk_rev;
   logic [15:0] rsp_chunk_flags;
   logic [31:0] rsp_payload_length;

   int mismatch_count;
   int awaiting;
   int file_count;
   int bad_file_count;
   int chunk_count;

   int         cycle_count = 0;
   int         stall_left = 0;
   logic       gap_on = 1'b0;
   logic       stall_on = 1'b0;
   logic [7:0] file_q[$];

   always #6 clock = ~clock;

   chunked_record_stream_checker u_top (.*);

   chunk_parse_monitor u_monitor (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!gap_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_tag();
      case ($urandom_range(0, 6))
         0:       return TYPE_META;
         1:       return TYPE_CONF;
         2:       return TYPE_RUNO;
         3, 4:    return TYPE_GT2R;
         5:       return TYPE_GT2R ^ (32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(0, 6);
      end
      if (r < 95) begin
         return $urandom_range(7, 24);
      end
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic chunk_fault_type pick_fault();
      int r;
      r = $urandom_range(0, 99);
      if (r < 84) begin
         return FAULT_NONE;
      end
      if (r < 92) begin
         return FAULT_CRC;
      end
      return FAULT_UNIT;
   endfunction

   task automatic add_byte(input logic [7:0] value);
      file_q.insert(file_q.size(), value);
   endtask

   task automatic push_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         add_byte(value[8*i +: 8]);
      end
   endtask

   task automatic cut_to(input int nbytes);
      while (file_q.size() > nbytes) begin
         void'(file_q.pop_back());
      end
   endtask

   task automatic add_header(input logic [7:0] part);
      for (int i = 0; i < HEADER_BYTES; i++) begin
         if (i < FIXED_BYTES) begin
            add_byte(FILE_PREAMBLE[i]);
         end else if (i == PART_OFFSET) begin
            add_byte(part);
         end else begin
            add_byte(8'($urandom));
         end
      end
   endtask

   task automatic add_chunk_header(input logic [31:0] tag, input logic [15:0] ver,
                                   input logic [15:0] flg, input logic [31:0] len,
                                   input logic [31:0] crc);
      push_le(tag, 4);
      push_le({flg, ver}, 4);
      push_le(len, 4);
      push_le(crc, 4);
   endtask

   task automatic add_chunk(input logic [31:0] tag, input int len,
                            input chunk_fault_type fault,
                            input logic [15:0] ver, input logic [15:0] flg);
      logic [7:0]  body[$];
      logic [31:0] acc;
      logic [31:0] sum;
      int          idx;
      acc = CRC_INIT;
      for (int i = 0; i < len; i++) begin
         body.insert(body.size(), 8'($urandom));
      end
      if (tag == TYPE_GT2R && len >= 2) begin
         body[0] = 8'd1;
         body[1] = 8'd3;
         if (fault == FAULT_UNIT) begin
            idx = $urandom_range(0, 1);
            body[idx] = body[idx] ^ 8'($urandom_range(1, 255));
         end
      end
      foreach (body[i]) begin
         acc = crc_fold_byte(acc, body[i]);
      end
      sum = ~acc;
      if (fault == FAULT_CRC) begin
         sum = sum ^ (32'h1 << $urandom_range(0, 31));
      end
      add_chunk_header(tag, ver, flg, 32'(len), sum);
      foreach (body[i]) begin
         add_byte(body[i]);
      end
   endtask

   task automatic build_random_file();
      int nchunks;
      int mode;
      int idx;
      nchunks = $urandom_range(0, 3);
      mode    = $urandom_range(0, 99);
      add_header(8'($urandom));
      repeat (nchunks) begin
         add_chunk(pick_tag(), pick_len(), pick_fault(), pick_half(), pick_half());
      end
      if (mode < 10) begin
         idx = $urandom_range(0, FIXED_BYTES - 1);
         file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
      end else if (mode < 22) begin
         cut_to($urandom_range(1, file_q.size() - 1));
      end else if (mode < 34) begin
         // stop partway into one more chunk header
         add_chunk(pick_tag(), 0, FAULT_NONE, 16'h0000, 16'h0000);
         cut_to(file_q.size() - CHUNK_HDR_LEN +
                (($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 15)));
      end
   endtask

   // starts and ends at a falling edge
   task automatic drive_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= data;
      req_end_of_file <= last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic send_file();
      gap_on   = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < file_q.size(); i++) begin
         drive_byte(file_q[i], i == file_q.size() - 1);
      end
      file_q.delete();
   endtask

   initial begin
      int random_bytes;
      random_bytes = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bad magic on the very first byte
      add_byte(8'h00);
      send_file();
      // bad version byte, rest drained
      add_header(8'h5A);
      file_q[10] = 8'h03;
      cut_to(24);
      send_file();
      // end inside the file header
      add_header(8'h11);
      cut_to(30);
      send_file();
      // header only, ends on its last byte
      add_header(8'hFF);
      send_file();
      // good chunks of every kind, then end after two type bytes
      add_header(8'h00);
      add_chunk(TYPE_META, 0, FAULT_NONE, 16'h0000, 16'h0000);
      add_chunk(TYPE_GT2R, 5, FAULT_NONE, 16'hFFFF, 16'hFFFF);
      add_chunk(TYPE_CONF, 3, FAULT_NONE, 16'h0001, 16'h8000);
      add_chunk(TYPE_RUNO, 4, FAULT_NONE, 16'h1234, 16'h00FF);
      add_chunk(32'h0000_0000, 2, FAULT_NONE, 16'hFFFF, 16'h0000);
      push_le(TYPE_META, 2);
      send_file();
      // empty gt2r payload
      add_header(8'h42);
      add_chunk(TYPE_GT2R, 0, FAULT_NONE, 16'h0000, 16'h0000);
      send_file();
      // one-byte gt2r payload
      add_header(8'h43);
      add_chunk(TYPE_GT2R, 1, FAULT_NONE, 16'h0001, 16'h0001);
      send_file();
      // wrong gt2r unit or count
      add_header(8'h44);
      add_chunk(TYPE_GT2R, 4, FAULT_UNIT, 16'h0002, 16'h0000);
      send_file();
      // crc mismatch, next chunk drained
      add_header(8'h45);
      add_chunk(TYPE_CONF, 3, FAULT_CRC, 16'h0000, 16'h0000);
      add_chunk(TYPE_META, 2, FAULT_NONE, 16'h0000, 16'h0000);
      send_file();
      // empty payload with nonzero crc
      add_header(8'h46);
      add_chunk(TYPE_META, 0, FAULT_CRC, 16'h0000, 16'h0000);
      send_file();
      // huge length, file ends inside the payload
      add_header(8'h47);
      add_chunk_header(TYPE_RUNO, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(8'hAA);
      send_file();
      // end after all four type bytes
      add_header(8'h48);
      add_chunk(TYPE_META, 3, FAULT_NONE, 16'h0000, 16'h0000);
      push_le(TYPE_CONF, 4);
      send_file();
      // end on the last chunk header byte with payload still due
      add_header(8'h49);
      add_chunk(TYPE_CONF, 5, FAULT_NONE, 16'h0000, 16'h0000);
      cut_to(file_q.size() - 5);
      send_file();

      while (random_bytes < 400) begin
         build_random_file();
         random_bytes += file_q.size();
         send_file();
      end
      req_valid <= 1'b0;

      while (awaiting != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      $display("ran %0d files, %0d ending with an error code, %0d chunks passing their checks",
               file_count, bad_file_count, chunk_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
